[rtl/hhpd_pkg.sv]
// Shared types and constants for the heading-hold PID drive.
package hhpd_pkg;

    // Divider geometry: 64-bit dividend, 20-bit divisor, two quotient bits per cycle
    localparam int DIV_NUM_W  = 64;
    localparam int DIV_DEN_W  = 20;
    localparam int DIV_STEPS  = DIV_NUM_W / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_BASE_SPEED       = 3'd0;
    localparam t_cfg_idx CFG_GAIN_P           = 3'd1;
    localparam t_cfg_idx CFG_GAIN_I           = 3'd2;
    localparam t_cfg_idx CFG_GAIN_D           = 3'd3;
    localparam t_cfg_idx CFG_CORRECTION_LIMIT = 3'd4;
    localparam t_cfg_idx CFG_INTEGRAL_LIMIT   = 3'd5;
    localparam t_cfg_idx CFG_INVERT_OUTPUT    = 3'd6;

    // Register reset values
    localparam logic [6:0]  RST_BASE_SPEED       = 7'd80;
    localparam logic [15:0] RST_GAIN_P           = 16'd256;
    localparam logic [15:0] RST_GAIN_I           = 16'd0;
    localparam logic [15:0] RST_GAIN_D           = 16'd26;
    localparam logic [6:0]  RST_CORRECTION_LIMIT = 7'd30;
    localparam logic [9:0]  RST_INTEGRAL_LIMIT   = 10'd100;
    localparam logic        RST_INVERT_OUTPUT    = 1'b1;

    // Item kinds
    localparam logic KIND_CAPTURE = 1'b0;

    // Heading in 1/16 degree
    localparam logic signed [13:0] HALF_TURN = 14'sd2880;
    localparam logic signed [13:0] FULL_TURN = 14'sd5760;

    localparam logic [15:0]          DEFAULT_DT_US = 16'd10000;
    localparam logic [DIV_DEN_W-1:0] US_PER_S      = 20'd1000000;
    localparam logic signed [8:0]    SPEED_MAX     = 9'sd100;
    localparam logic [63:0]          ROUND_HALF    = 64'h0000_0000_0080_0000;

    typedef enum logic [18:0] {
        ST_IDLE   = 19'h00001,
        ST_ERR    = 19'h00002,
        ST_LIM    = 19'h00004,
        ST_IPROD  = 19'h00008,
        ST_IACC   = 19'h00010,
        ST_ICLAMP = 19'h00020,
        ST_PTERM  = 19'h00040,
        ST_ILO    = 19'h00080,
        ST_IHI    = 19'h00100,
        ST_ISUM   = 19'h00200,
        ST_ISTART = 19'h00400,
        ST_IWAIT  = 19'h00800,
        ST_DMUL1  = 19'h01000,
        ST_DMUL2  = 19'h02000,
        ST_DSTART = 19'h04000,
        ST_DWAIT  = 19'h08000,
        ST_FIN1   = 19'h10000,
        ST_FIN2   = 19'h20000,
        ST_SPD    = 19'h40000
    } t_state;

endpackage

[rtl/hhpd_div.sv]
// Unsigned restoring divider, two quotient bits per cycle.
module hhpd_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [hhpd_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [hhpd_pkg::DIV_DEN_W-1:0] i_den,
    output logic                           o_done,
    output logic [hhpd_pkg::DIV_NUM_W-1:0] o_quot
);
    import hhpd_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_NUM_W-1:0] r_q;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;

    logic [DIV_DEN_W:0]   t1;
    logic [DIV_DEN_W:0]   t2;
    logic                 ge1;
    logic                 ge2;
    logic [DIV_DEN_W-1:0] rem1;
    logic [DIV_DEN_W-1:0] rem2;

    always_comb begin
        t1   = {r_rem, r_q[DIV_NUM_W-1]};
        ge1  = t1 >= {1'b0, r_den};
        rem1 = ge1 ? DIV_DEN_W'(t1 - {1'b0, r_den}) : t1[DIV_DEN_W-1:0];
        t2   = {rem1, r_q[DIV_NUM_W-2]};
        ge2  = t2 >= {1'b0, r_den};
        rem2 = ge2 ? DIV_DEN_W'(t2 - {1'b0, r_den}) : t2[DIV_DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Dividend shifts out at the top while quotient bits shift in at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_NUM_W-3:0], ge1, ge2};
            r_rem <= rem2;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

[rtl/heading_hold_pid_drive.sv]
// Heading-hold PID steering controller for a differential drive, top level.
// A capture item (tuser 0) stores the yaw as the target heading, clears the integral
// and previous error, and goes straight to the result step, which returns base speed
// on both wheels once the output register is free. For a control step item (tuser 1)
// a small sequencer runs the error wrap, the clamped integral and the P, I and D
// terms through one shared 32x20 multiplier and one radix-4 divider, with two divider
// passes (integral term over 1e6, derivative term over dt). Input is taken only while
// the sequencer is idle; a finished result sits in the output register and the next
// item may be taken while it waits, one result per item.
module heading_hold_pid_drive (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [31:0]                     s_axis_tdata,  // [12:0] yaw_measured, [28:13] step_time_us
    input  logic                            s_axis_tuser,  // [0] kind
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [23:0]                     m_axis_tdata,  // [6:0] left_speed, [13:7] right_speed, [21:14] correction
    input  logic                            i_cfg_we,
    input  logic [hhpd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hhpd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import hhpd_pkg::*;

    function automatic logic [6:0] sat_speed(input logic signed [8:0] v);
        logic [6:0] s;
        if (v < 0)
            s = 7'd0;
        else if (v > SPEED_MAX)
            s = SPEED_MAX[6:0];
        else
            s = v[6:0];
        return s;
    endfunction

    // Configuration
    logic [6:0]  r_base;
    logic [15:0] r_gain_p;
    logic [15:0] r_gain_i;
    logic [15:0] r_gain_d;
    logic [6:0]  r_corr_lim;
    logic [9:0]  r_int_lim;
    logic        r_invert;

    // Controller state
    t_state              r_state;
    logic signed [12:0]  r_target;
    logic signed [39:0]  r_integ;
    logic signed [12:0]  r_prev;

    // Per-item working registers
    logic signed [12:0]  r_yaw;
    logic [15:0]         r_dt;
    logic signed [12:0]  r_err;
    logic signed [13:0]  r_de;
    logic [33:0]         r_lim;
    logic [39:0]         r_imag;
    logic                r_ineg;
    logic [51:0]         r_prod;
    logic [51:0]         r_num;
    logic signed [63:0]  r_acc;
    logic                r_neg;
    logic signed [7:0]   r_corr;

    // Output register
    logic                r_m_valid;
    logic [6:0]          r_m_left;
    logic [6:0]          r_m_right;
    logic signed [7:0]   r_m_corr;

    logic                s_accept;
    logic signed [12:0]  in_yaw;
    logic [15:0]         in_dt;
    logic signed [13:0]  diff;
    logic signed [13:0]  diff_w;
    logic [11:0]         err_abs;
    logic [12:0]         de_abs;
    logic signed [39:0]  prod_s;
    logic signed [39:0]  lim_s;
    logic signed [39:0]  integ_add;
    logic signed [63:0]  pterm;
    logic signed [63:0]  quot_s;
    logic [63:0]         rnd;
    logic [39:0]         whole;
    logic [6:0]          corr_mag;
    logic signed [8:0]   sum_l;
    logic signed [8:0]   sum_r;
    logic                out_free;

    logic [31:0]         mul_a;
    logic [19:0]         mul_b;
    logic [51:0]         mul_p;

    logic                         div_start;
    logic [DIV_NUM_W-1:0]         div_num;
    logic [DIV_DEN_W-1:0]         div_den;
    logic                         div_done;
    logic [DIV_NUM_W-1:0]         div_quot;

    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign in_yaw   = $signed(s_axis_tdata[12:0]);
    assign in_dt    = s_axis_tdata[28:13];
    assign out_free = !r_m_valid || m_axis_tready;

    always_comb begin
        diff = {r_target[12], r_target} - {r_yaw[12], r_yaw};
        if (diff > HALF_TURN)
            diff_w = diff - FULL_TURN;
        else if (diff < -HALF_TURN)
            diff_w = diff + FULL_TURN;
        else
            diff_w = diff;
    end

    assign err_abs   = r_err[12] ? 12'(-r_err) : 12'(r_err);
    assign de_abs    = r_de[13] ? 13'(-r_de) : 13'(r_de);
    assign prod_s    = $signed({12'b0, r_prod[27:0]});
    assign lim_s     = $signed({6'b0, r_lim});
    assign integ_add = r_err[12] ? r_integ - prod_s : r_integ + prod_s;
    assign pterm     = $signed({24'b0, r_prod[27:0], 12'b0});
    assign quot_s    = $signed(div_quot);
    assign rnd       = r_acc + ROUND_HALF;
    assign whole     = rnd[63:24];
    assign corr_mag  = (whole > {33'b0, r_corr_lim}) ? r_corr_lim : whole[6:0];
    assign sum_l     = $signed({2'b0, r_base}) + {r_corr[7], r_corr};
    assign sum_r     = $signed({2'b0, r_base}) - {r_corr[7], r_corr};

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_LIM: begin
                mul_a = {22'b0, r_int_lim};
                mul_b = US_PER_S;
            end
            ST_IPROD: begin
                mul_a = {16'b0, r_dt};
                mul_b = {8'b0, err_abs};
            end
            ST_ICLAMP: begin
                mul_a = {16'b0, r_gain_p};
                mul_b = {8'b0, err_abs};
            end
            ST_ILO: begin
                mul_a = {16'b0, r_gain_i};
                mul_b = r_imag[19:0];
            end
            ST_IHI: begin
                mul_a = {16'b0, r_gain_i};
                mul_b = r_imag[39:20];
            end
            ST_DMUL1: begin
                mul_a = {16'b0, r_gain_d};
                mul_b = {7'b0, de_abs};
            end
            ST_DMUL2: begin
                mul_a = r_prod[31:0];
                mul_b = US_PER_S;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = {20'b0, mul_a} * {32'b0, mul_b};

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
    end

    assign div_start = (r_state == ST_ISTART) || (r_state == ST_DSTART);
    assign div_num   = (r_state == ST_DSTART) ? {r_prod, 12'b0} : {r_num, 12'b0};
    assign div_den   = (r_state == ST_DSTART) ? {4'b0, r_dt} : US_PER_S;

    hhpd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= RST_BASE_SPEED;
            r_gain_p   <= RST_GAIN_P;
            r_gain_i   <= RST_GAIN_I;
            r_gain_d   <= RST_GAIN_D;
            r_corr_lim <= RST_CORRECTION_LIMIT;
            r_int_lim  <= RST_INTEGRAL_LIMIT;
            r_invert   <= RST_INVERT_OUTPUT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BASE_SPEED:       r_base     <= i_cfg_data[6:0];
                CFG_GAIN_P:           r_gain_p   <= i_cfg_data;
                CFG_GAIN_I:           r_gain_i   <= i_cfg_data;
                CFG_GAIN_D:           r_gain_d   <= i_cfg_data;
                CFG_CORRECTION_LIMIT: r_corr_lim <= i_cfg_data[6:0];
                CFG_INTEGRAL_LIMIT:   r_int_lim  <= i_cfg_data[9:0];
                CFG_INVERT_OUTPUT:    r_invert   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_target  <= '0;
            r_integ   <= '0;
            r_prev    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (r_m_valid && m_axis_tready)
                r_m_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (s_accept) begin
                        if (s_axis_tuser == KIND_CAPTURE) begin
                            r_target <= in_yaw;
                            r_integ  <= '0;
                            r_prev   <= '0;
                            r_state  <= ST_SPD;
                        end else begin
                            r_state <= ST_ERR;
                        end
                    end
                end
                ST_ERR:    r_state <= ST_LIM;
                ST_LIM: begin
                    r_prev  <= r_err;
                    r_state <= ST_IPROD;
                end
                ST_IPROD:  r_state <= ST_IACC;
                ST_IACC: begin
                    r_integ <= integ_add;
                    r_state <= ST_ICLAMP;
                end
                ST_ICLAMP: begin
                    if (r_integ > lim_s)
                        r_integ <= lim_s;
                    else if (r_integ < -lim_s)
                        r_integ <= -lim_s;
                    r_state <= ST_PTERM;
                end
                ST_PTERM:  r_state <= ST_ILO;
                ST_ILO:    r_state <= ST_IHI;
                ST_IHI:    r_state <= ST_ISUM;
                ST_ISUM:   r_state <= ST_ISTART;
                ST_ISTART: r_state <= ST_IWAIT;
                ST_IWAIT: begin
                    if (div_done)
                        r_state <= ST_DMUL1;
                end
                ST_DMUL1:  r_state <= ST_DMUL2;
                ST_DMUL2:  r_state <= ST_DSTART;
                ST_DSTART: r_state <= ST_DWAIT;
                ST_DWAIT: begin
                    if (div_done)
                        r_state <= ST_FIN1;
                end
                ST_FIN1:   r_state <= ST_FIN2;
                ST_FIN2:   r_state <= ST_SPD;
                ST_SPD: begin
                    // hold until the output register is free
                    if (out_free) begin
                        r_m_valid <= 1'b1;
                        r_state   <= ST_IDLE;
                    end
                end
                default:   r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_yaw  <= in_yaw;
                r_dt   <= (in_dt == 16'd0) ? DEFAULT_DT_US : in_dt;
                r_corr <= '0;
            end
            ST_ERR: r_err <= diff_w[12:0];
            ST_LIM: r_de  <= {r_err[12], r_err} - {r_prev[12], r_prev};
            ST_IPROD: r_lim <= {r_prod[29:0], 4'b0};
            ST_PTERM: begin
                r_acc  <= r_err[12] ? -pterm : pterm;
                r_imag <= r_integ[39] ? 40'(-r_integ) : 40'(r_integ);
                r_ineg <= r_integ[39];
            end
            ST_IHI:  r_num <= r_prod;
            ST_ISUM: r_num <= r_num + {r_prod[31:0], 20'b0};
            ST_IWAIT: begin
                if (div_done)
                    r_acc <= r_ineg ? r_acc - quot_s : r_acc + quot_s;
            end
            ST_DWAIT: begin
                if (div_done)
                    r_acc <= r_de[13] ? r_acc - quot_s : r_acc + quot_s;
            end
            ST_FIN1: begin
                // fold the optional sign flip into the sign; keep the magnitude
                r_neg <= r_invert ? (r_acc > 0) : (r_acc < 0);
                r_acc <= r_acc[63] ? -r_acc : r_acc;
            end
            ST_FIN2: r_corr <= r_neg ? -$signed({1'b0, corr_mag}) : $signed({1'b0, corr_mag});
            ST_SPD: begin
                if (out_free) begin
                    r_m_left  <= sat_speed(sum_l);
                    r_m_right <= sat_speed(sum_r);
                    r_m_corr  <= r_corr;
                end
            end
            default: begin
            end
        endcase
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {2'b0, r_m_corr, r_m_right, r_m_left};

`ifndef SYNTHESIS
    a_integ_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PTERM) |-> (r_integ <= lim_s && r_integ >= -lim_s))
        else $error("integral outside its clamp after the clamp step");

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_IWAIT || r_state == ST_DWAIT))
        else $error("divider finished while the sequencer was not waiting");

    a_capture_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && s_axis_tuser == KIND_CAPTURE) |=> (r_state == ST_SPD))
        else $error("capture item did not go straight to the result step");

    a_speed_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> (r_m_left <= 7'd100 && r_m_right <= 7'd100))
        else $error("wheel speed above saturation");
`endif

endmodule
